@@ src/fscm_pkg.sv @@
package fscm_pkg;

  // Operation codes carried by the opcode field.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REJ_MEM  = 2'd1;
  localparam logic [1:0] STATUS_REJ_FULL = 2'd2;
  localparam logic [1:0] STATUS_MISS     = 2'd3;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MAX_CACHED    = 8'd0;
  localparam logic [7:0] CFG_EXPIRY_MS     = 8'd1;
  localparam logic [7:0] CFG_MEMORY_LIMIT  = 8'd2;
  localparam logic [7:0] CFG_RESERVE_BYTES = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [6:0]  MAX_CACHED_RST    = 7'd8;
  localparam logic [31:0] EXPIRY_MS_RST     = 32'd5000;
  localparam logic [31:0] MEMORY_LIMIT_RST  = 32'd104857600;
  localparam logic [31:0] RESERVE_BYTES_RST = 32'd8388608;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH,
    S_ADD_WR,
    S_GN_SCAN,
    S_GN_READ,
    S_CLEAR,
    S_DONE
  } state_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [30:0] frame_id;
    logic [31:0] load_time;
    logic [31:0] bytes;
  } slot_entry_t;

  // Subtraction that stops at zero.
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a >= b) ? (a - b) : 32'd0;
  endfunction

  // Addition that stops at the all-ones value.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ src/frame_slot_cache_manager_core.sv @@
// Frame slot cache manager.
// A request on the input channel (in_valid, in_stall) carries an opcode and the
// frame fields; exactly one result per request leaves on the output channel
// (out_valid, out_stall). A request is taken only while the manager is idle.
// An add that is not rejected, and every expire, sweeps the slot memory once,
// one entry per cycle; the add then writes the new frame. Get next walks the
// valid bits round-robin from the read pointer, one slot per cycle, and then
// reads the hit entry. Rejected adds and misses on an empty cache go straight
// to the result state, and clear empties the table in its own state first.
// The finished result sits in an output register. A new request is taken while
// that result is still stalled; its own result is held back until the output
// register has been emptied.
// Configuration writes (cfg_valid, cfg_ready) are always taken, one per cycle.
// Reset empties the table, zeroes the count, the pointer and the byte total,
// and loads the register defaults. The slot memory itself is not cleared: the
// valid bits, held in flip-flops, mark which entries may be read.
module frame_slot_cache_manager_core
  import fscm_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [30:0] frame_id,
  input  logic [31:0] frame_bytes,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  slot,
  output logic [30:0] out_frame_id,
  output logic [31:0] out_frame_bytes,
  output logic [6:0]  expired_count,
  output logic [6:0]  cached_count,
  output logic [31:0] bytes_in_use,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOT_CNT = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS - 1);

  // Configuration registers.
  logic [6:0]  max_cached;
  logic [31:0] expiry_ms;
  logic [31:0] memory_limit;
  logic [31:0] reserve_bytes;

  // Control state.
  state_t            state, state_next;
  logic [SLOTS-1:0]  valid;
  logic [6:0]        valid_count;
  logic [5:0]        read_pointer;
  logic [31:0]       used_bytes;
  logic [CW-1:0]     cnt;
  logic              pend;
  logic [6:0]        exp_cnt;

  // Request and scan payload.
  logic [1:0]        op;
  logic [30:0]       fid;
  logic [31:0]       fbytes;
  logic [31:0]       now;
  logic [IW-1:0]     pend_idx;
  logic [IW-1:0]     gn_idx;
  logic [IW-1:0]     pick;
  logic [IW-1:0]     pick_empty;
  logic [IW-1:0]     pick_old;
  logic              empty_found;
  logic              old_found;
  logic [31:0]       best_age;
  logic [31:0]       best_bytes;
  logic [1:0]        res_status;
  logic [5:0]        res_slot;
  logic [30:0]       res_fid;
  logic [31:0]       res_bytes;

  // Slot memory with a registered read port.
  slot_entry_t       mem [SLOTS];
  slot_entry_t       rd_data;
  logic [IW-1:0]     mem_addr;
  logic              mem_we;

  logic              in_accept;
  logic              mem_rej;
  logic              full_rej;
  logic [31:0]       age;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // The sum is formed one bit wider so that it never wraps.
  assign mem_rej  = ({1'b0, used_bytes} + {1'b0, reserve_bytes}) > {1'b0, memory_limit};
  assign full_rej = (valid_count >= max_cached);

  // Age of the entry whose read data has just come back.
  assign age = now - rd_data.load_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cached    <= MAX_CACHED_RST;
      expiry_ms     <= EXPIRY_MS_RST;
      memory_limit  <= MEMORY_LIMIT_RST;
      reserve_bytes <= RESERVE_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_CACHED:    max_cached    <= cfg_data[6:0];
        CFG_EXPIRY_MS:     expiry_ms     <= cfg_data;
        CFG_MEMORY_LIMIT:  memory_limit  <= cfg_data;
        CFG_RESERVE_BYTES: reserve_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory address and write enable.
  always_comb begin
    state_next = state;
    mem_addr   = cnt[IW-1:0];
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode)
            OP_ADD:    state_next = (mem_rej || full_rej) ? S_DONE : S_SWEEP;
            OP_GET:    state_next = (valid_count == 7'd0) ? S_DONE : S_GN_SCAN;
            OP_EXPIRE: state_next = S_SWEEP;
            default:   state_next = S_CLEAR;
          endcase
        end
      end
      S_SWEEP: begin
        if (cnt == SLOT_CNT && !pend) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = (op == OP_ADD) ? S_ADD_WR : S_DONE;
      end
      S_ADD_WR: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_GN_SCAN: begin
        mem_addr = gn_idx;
        if (valid[gn_idx]) begin
          state_next = S_GN_READ;
        end else if (cnt == LAST_CNT) begin
          state_next = S_DONE;
        end
      end
      S_GN_READ: state_next = S_DONE;
      S_CLEAR:   state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pick] <= '{frame_id: fid, load_time: now, bytes: fbytes};
    end
    rd_data <= mem[mem_addr];
  end

  // Table state, counters and the output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      valid_count  <= 7'd0;
      read_pointer <= 6'd0;
      used_bytes   <= 32'd0;
      cnt          <= '0;
      pend         <= 1'b0;
      exp_cnt      <= 7'd0;
      out_valid    <= 1'b0;
    end else begin
      // The output register fills from the result state and empties when taken.
      out_valid <= (state == S_DONE) || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cnt     <= '0;
            pend    <= 1'b0;
            exp_cnt <= 7'd0;
          end
        end
        S_SWEEP: begin
          // One read is issued per cycle; its data is handled in the next one.
          if (cnt != SLOT_CNT) begin
            cnt <= cnt + CW'(1);
          end
          pend <= (cnt != SLOT_CNT);
          if (pend && op == OP_EXPIRE && valid[pend_idx] && age > expiry_ms) begin
            used_bytes      <= sat_sub(used_bytes, rd_data.bytes);
            valid[pend_idx] <= 1'b0;
            exp_cnt         <= exp_cnt + 7'd1;
          end
        end
        S_FINISH: begin
          if (op == OP_ADD) begin
            // With no empty slot the oldest frame gives its bytes back first.
            if (!empty_found) begin
              used_bytes <= sat_sub(used_bytes, best_bytes);
              if (valid_count != 7'd0) begin
                valid_count <= valid_count - 7'd1;
              end
            end
          end else begin
            valid_count <= (valid_count >= exp_cnt) ? (valid_count - exp_cnt) : 7'd0;
          end
        end
        S_ADD_WR: begin
          valid[pick] <= 1'b1;
          valid_count <= valid_count + 7'd1;
          used_bytes  <= sat_add(used_bytes, fbytes);
        end
        S_GN_SCAN: begin
          if (!valid[gn_idx]) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_GN_READ: begin
          read_pointer <= (pick == LAST_IDX) ? 6'd0 : 6'(pick + IW'(1));
        end
        S_CLEAR: begin
          valid        <= '0;
          valid_count  <= 7'd0;
          read_pointer <= 6'd0;
          used_bytes   <= 32'd0;
        end
        default: ;
      endcase
    end
  end

  // Request fields, scan results and the output payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          op          <= opcode;
          fid         <= frame_id;
          fbytes      <= frame_bytes;
          now         <= now_ms;
          gn_idx      <= read_pointer[IW-1:0];
          empty_found <= 1'b0;
          old_found   <= 1'b0;
          res_slot    <= 6'd0;
          res_fid     <= 31'd0;
          res_bytes   <= 32'd0;
          case (opcode)
            OP_ADD: begin
              if (mem_rej) begin
                res_status <= STATUS_REJ_MEM;
              end else if (full_rej) begin
                res_status <= STATUS_REJ_FULL;
              end else begin
                res_status <= STATUS_OK;
              end
            end
            OP_GET:  res_status <= STATUS_MISS;
            default: res_status <= STATUS_OK;
          endcase
        end
      end
      S_SWEEP: begin
        pend_idx <= cnt[IW-1:0];
        if (pend && op == OP_ADD) begin
          // Lowest empty slot, and the oldest valid one with ties to the lowest.
          if (!valid[pend_idx]) begin
            if (!empty_found) begin
              empty_found <= 1'b1;
              pick_empty  <= pend_idx;
            end
          end else if (!old_found || age > best_age) begin
            old_found  <= 1'b1;
            best_age   <= age;
            pick_old   <= pend_idx;
            best_bytes <= rd_data.bytes;
          end
        end
      end
      S_FINISH: begin
        pick <= empty_found ? pick_empty : pick_old;
      end
      S_ADD_WR: begin
        res_slot <= 6'(pick);
      end
      S_GN_SCAN: begin
        if (valid[gn_idx]) begin
          pick <= gn_idx;
        end else begin
          gn_idx <= (gn_idx == LAST_IDX) ? '0 : gn_idx + IW'(1);
        end
      end
      S_GN_READ: begin
        res_status <= STATUS_OK;
        res_slot   <= 6'(pick);
        res_fid    <= rd_data.frame_id;
        res_bytes  <= rd_data.bytes;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          status          <= res_status;
          slot            <= res_slot;
          out_frame_id    <= res_fid;
          out_frame_bytes <= res_bytes;
          expired_count   <= exp_cnt;
          cached_count    <= valid_count;
          bytes_in_use    <= used_bytes;
        end
      end
      default: ;
    endcase
  end

  // The count of valid frames always agrees with the valid bits between requests.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(valid) == valid_count))
    else $error("valid_count disagrees with the valid bits");

  // The read pointer always names a slot that exists.
  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, read_pointer} < 7'(SLOTS))
    else $error("read pointer beyond the table");

  // A written slot is marked valid right after the write.
  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> valid[$past(pick)])
    else $error("slot written but not marked valid");

  // A new result only appears out of the result state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the result state");

  // An add that was not rejected leaves at least one valid frame.
  a_add_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_WR) |=> (valid_count != 7'd0))
    else $error("add left the cache empty");

endmodule
